@@ rtl/jfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_pkg
// Shared types, marker codes and helpers for the JPEG frame size scanner.
// ----------------------------------------------------------------------------
package jfs_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned DimW  = 16;

    // Marker byte codes
    localparam logic [ByteW-1:0] MK_PREFIX = 8'hFF;
    localparam logic [ByteW-1:0] MK_SOI    = 8'hD8;
    localparam logic [ByteW-1:0] MK_EOI    = 8'hD9;
    localparam logic [ByteW-1:0] MK_RST0   = 8'hD0;
    localparam logic [ByteW-1:0] MK_RST7   = 8'hD7;
    localparam logic [ByteW-1:0] MK_TEM    = 8'h01;
    localparam logic [ByteW-1:0] MK_STUFF  = 8'h00;
    localparam logic [ByteW-1:0] MK_SOF0   = 8'hC0;
    localparam logic [ByteW-1:0] MK_SOF3   = 8'hC3;
    localparam logic [ByteW-1:0] MK_SOF5   = 8'hC5;
    localparam logic [ByteW-1:0] MK_SOF7   = 8'hC7;
    localparam logic [ByteW-1:0] MK_SOF9   = 8'hC9;
    localparam logic [ByteW-1:0] MK_SOF13  = 8'hCD;
    localparam logic [ByteW-1:0] MK_SOF11  = 8'hCB;
    localparam logic [ByteW-1:0] MK_SOF15  = 8'hCF;

    // Segment length bounds (length counts its own two bytes)
    localparam logic [DimW-1:0] LEN_MIN     = 16'd2;
    localparam logic [DimW-1:0] SOF_PAY_MIN = 16'd6;

    // SOF payload positions: precision, height hi/lo, width hi/lo
    localparam logic [2:0] POS_HEIGHT_HI = 3'd1;
    localparam logic [2:0] POS_HEIGHT_LO = 3'd2;
    localparam logic [2:0] POS_WIDTH_HI  = 3'd3;
    localparam logic [2:0] POS_WIDTH_LO  = 3'd4;
    localparam logic [2:0] POS_END       = 3'd5;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [2:0] {
        PH_DONE    = 3'd0,
        PH_SOI2    = 3'd1,
        PH_HUNT    = 3'd2,
        PH_MARKER  = 3'd3,
        PH_LENHI   = 3'd4,
        PH_LENLO   = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    typedef struct packed {
        logic            status;
        logic [DimW-1:0] image_width;
        logic [DimW-1:0] image_height;
    } jfs_result_t;

    typedef struct packed {
        logic        valid;
        jfs_result_t word;
    } jfs_push_t;

    // Start-of-frame markers that carry frame dimensions
    function automatic logic is_frame_marker(input logic [ByteW-1:0] m);
        return (m >= MK_SOF0  && m <= MK_SOF3)  ||
               (m >= MK_SOF5  && m <= MK_SOF7)  ||
               (m >= MK_SOF9  && m <= MK_SOF11) ||
               (m >= MK_SOF13 && m <= MK_SOF15);
    endfunction

    // Markers that stand alone with no length field
    function automatic logic is_bare_marker(input logic [ByteW-1:0] m);
        return (m == MK_STUFF) || (m == MK_SOI) || (m == MK_EOI) ||
               (m == MK_TEM) || (m >= MK_RST0 && m <= MK_RST7);
    endfunction

endpackage

@@ rtl/jfs_byte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_byte_if
// Byte stream channel: one file byte per word with first/last marks.
// ----------------------------------------------------------------------------
interface jfs_byte_if
    import jfs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             first;
    logic             last;

    modport source (output valid, output data_byte, output first, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input first, input last,
                    output ready);
endinterface

@@ rtl/jfs_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_result_if
// Result channel: scan status and frame dimensions.
// ----------------------------------------------------------------------------
interface jfs_result_if
    import jfs_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            status;
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;

    modport source (output valid, output status, output image_width,
                    output image_height, input ready);
    modport sink   (input valid, input status, input image_width,
                    input image_height, output ready);
endinterface

@@ rtl/jfs_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_scanner
// Marker segment parser: updates the scan state once per accepted byte word
// and pushes a result word when the scan ends.
// ----------------------------------------------------------------------------
module jfs_scanner
    import jfs_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    jfs_byte_if.sink       stream,
    input  logic           buf_ready,
    output jfs_push_t      push
);

    phase_t          phase_reg, phase_next;
    logic [DimW-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]      length_high_reg, length_high_next;
    logic            in_fh_reg, in_fh_next;
    logic [2:0]      header_pos_reg, header_pos_next;
    logic [DimW-1:0] held_height_reg, held_height_next;
    logic [DimW-1:0] held_width_reg, held_width_next;

    logic            accept;
    logic [7:0]      b;
    logic [DimW-1:0] seg_len;
    logic [DimW-1:0] seg_pay;
    logic            seg_short;
    logic            fh_short;
    logic            hdr_active;
    logic [DimW-1:0] height_upd;
    logic [DimW-1:0] width_upd;
    logic            zero_size;
    logic [DimW-1:0] left_dec;
    logic            left_end;
    logic            emit;
    logic            emit_ok;

    assign accept       = stream.valid && stream.ready;
    assign stream.ready = buf_ready;
    assign b            = stream.data_byte;

    // Decode the segment length and the frame header fields
    always_comb
    begin
        seg_len    = {length_high_reg, b};
        seg_pay    = seg_len - LEN_MIN;
        seg_short  = seg_len < LEN_MIN;
        fh_short   = in_fh_reg && (seg_pay < SOF_PAY_MIN);
        hdr_active = in_fh_reg && (header_pos_reg < POS_END);
        height_upd = held_height_reg;
        width_upd  = held_width_reg;
        if (hdr_active)
        begin
            unique case (header_pos_reg)
                POS_HEIGHT_HI: height_upd = {b, held_height_reg[7:0]};
                POS_HEIGHT_LO: height_upd = {held_height_reg[15:8], b};
                POS_WIDTH_HI:  width_upd  = {b, held_width_reg[7:0]};
                POS_WIDTH_LO:  width_upd  = {held_width_reg[15:8], b};
                default:       ;
            endcase
        end
        zero_size = hdr_active && (header_pos_reg == POS_WIDTH_LO) &&
                    ((width_upd == '0) || (height_upd == '0));
        left_dec  = bytes_left_reg - 16'd1;
        left_end  = left_dec == '0;
    end

    // Result decision for the current byte word
    always_comb
    begin
        emit    = 1'b0;
        emit_ok = 1'b0;
        if (stream.first)
        begin
            emit = (b != MK_PREFIX) || stream.last;
        end
        else
        begin
            unique case (phase_reg)
                PH_SOI2:
                    emit = (b != MK_SOI) || stream.last;
                PH_HUNT, PH_MARKER, PH_LENHI:
                    emit = stream.last;
                PH_LENLO:
                    emit = seg_short || fh_short || stream.last;
                PH_PAYLOAD:
                begin
                    if (zero_size)
                        emit = 1'b1;
                    else if (left_end && in_fh_reg)
                    begin
                        emit    = 1'b1;
                        emit_ok = 1'b1;
                    end
                    else
                        emit = stream.last;
                end
                default: ;
            endcase
        end
    end

    // Next scan state
    always_comb
    begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        length_high_next = length_high_reg;
        in_fh_next       = in_fh_reg;
        header_pos_next  = header_pos_reg;
        held_height_next = held_height_reg;
        held_width_next  = held_width_reg;
        if (stream.first)
        begin
            phase_next       = PH_SOI2;
            bytes_left_next  = '0;
            length_high_next = '0;
            in_fh_next       = 1'b0;
            header_pos_next  = '0;
            held_height_next = '0;
            held_width_next  = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SOI2:
                    phase_next = PH_HUNT;
                PH_HUNT:
                    if (b == MK_PREFIX)
                        phase_next = PH_MARKER;
                PH_MARKER:
                begin
                    if (b == MK_PREFIX)
                        phase_next = PH_MARKER;
                    else if (is_bare_marker(b))
                        phase_next = PH_HUNT;
                    else
                    begin
                        in_fh_next = is_frame_marker(b);
                        phase_next = PH_LENHI;
                    end
                end
                PH_LENHI:
                begin
                    length_high_next = b;
                    phase_next       = PH_LENLO;
                end
                PH_LENLO:
                begin
                    header_pos_next = '0;
                    bytes_left_next = seg_pay;
                    phase_next      = (seg_pay == '0) ? PH_HUNT : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    held_height_next = height_upd;
                    held_width_next  = width_upd;
                    if (hdr_active)
                        header_pos_next = header_pos_reg + 3'd1;
                    bytes_left_next = left_dec;
                    if (left_end)
                        phase_next = PH_HUNT;
                end
                default:
                    phase_next = PH_DONE;
            endcase
        end
        // Any result closes the scan
        if (emit)
            phase_next = PH_DONE;
    end

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_DONE;
            bytes_left_reg  <= '0;
            length_high_reg <= '0;
            in_fh_reg       <= 1'b0;
            header_pos_reg  <= '0;
            held_height_reg <= '0;
            held_width_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            length_high_reg <= length_high_next;
            in_fh_reg       <= in_fh_next;
            header_pos_reg  <= header_pos_next;
            held_height_reg <= held_height_next;
            held_width_reg  <= held_width_next;
        end
    end

    // Push the result word to the output buffer
    always_comb
    begin
        push.valid             = accept && emit;
        push.word.status       = emit_ok ? STATUS_OK : STATUS_FAIL;
        push.word.image_width  = emit_ok ? width_upd : '0;
        push.word.image_height = emit_ok ? height_upd : '0;
    end

    // A result always leaves the scan finished
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |=> (phase_reg == PH_DONE))
        else $error("scan not finished after result");

    // A finished scan stays silent until a new first byte
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PH_DONE) && !stream.first) |-> !push.valid)
        else $error("result from finished scan");

    // The header position never runs past the end of the dimension fields
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_pos_reg <= POS_END)
        else $error("header position out of range");

endmodule

@@ rtl/jfs_out_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_out_buffer
// Output register with a skid stage, so the scanner keeps taking byte words
// while a result word waits on the result channel.
// ----------------------------------------------------------------------------
module jfs_out_buffer
    import jfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  jfs_push_t    push,
    output logic         buf_ready,
    jfs_result_if.source result
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    jfs_result_t main_reg, main_next;
    jfs_result_t skid_reg, skid_next;
    logic        pop;

    assign pop       = result.valid && result.ready;
    assign buf_ready = !skid_valid_reg;

    // Select where an incoming word lands and refill from the skid stage
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push.valid;
                main_next       = push.word;
            end
        end
        else if (push.valid)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = push.word;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = push.word;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign result.valid        = main_valid_reg;
    assign result.status       = main_reg.status;
    assign result.image_width  = main_reg.image_width;
    assign result.image_height = main_reg.image_height;

    // The skid stage only fills behind a full output register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word without output word");

    // No word arrives while the skid stage is full
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !skid_valid_reg)
        else $error("result word pushed into full buffer");

    // A taken word with a skid word behind it refills the output register
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid word lost on refill");

endmodule

@@ rtl/jpeg_frame_size_scanner_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner_core
// Scans a JPEG byte stream for the first frame header and reports its size.
// ----------------------------------------------------------------------------
// The core takes one file byte per cycle on the stream channel while stream
// ready is high and updates its marker parser in the same cycle. A scan ends
// in one result word (status 0 with width and height, or status 1 with zero
// dimensions), registered into the output register, or into the skid stage
// while that register holds an untaken word. The output register is backed by
// a one-word skid stage; stream ready drops only while both hold a word that
// the result channel has not taken. A byte marked first restarts the scan at
// any time; bytes after a result are dropped until then.
module jpeg_frame_size_scanner_core
    import jfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    jfs_byte_if.sink     stream,
    jfs_result_if.source result
);

    jfs_push_t push;
    logic      buf_ready;

    jfs_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .buf_ready (buf_ready),
        .push      (push)
    );

    jfs_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .buf_ready (buf_ready),
        .result    (result)
    );

endmodule
